// ===== hdl/gbtsd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbtsd_pkg
// Types, modulation codes and training/sync sequence tables for the GSM burst
// training sequence detector. Every table entry holds the first burst bit in
// its MSB.
// ----------------------------------------------------------------------------
package gbtsd_pkg;

  localparam int NRM_LEN   = 26;
  localparam int ACC_LEN   = 41;
  localparam int SYN_LEN   = 64;
  localparam int PSK_LEN   = 78;
  localparam int PSK_HALF  = 39;
  localparam int NRM_SETS  = 4;
  localparam int PSK_SETS  = 2;
  localparam int TSC_CODES = 8;
  localparam int ACC_SEQS  = 4;
  localparam int SYN_SEQS  = 4;

  typedef enum logic [1:0] {
    MOD_GMSK  = 2'd0,
    MOD_8PSK  = 2'd1,
    MOD_OTHER = 2'd2,
    MOD_SPARE = 2'd3
  } modulation_t;

  typedef struct packed {
    logic                is_nope;
    logic [1:0]          modulation;
    logic [2:0]          timeslot;
    logic [NRM_LEN-1:0]  normal_window;
    logic [ACC_LEN-1:0]  access_window;
    logic [SYN_LEN-1:0]  sync_window;
    logic [PSK_HALF-1:0] psk_window_first;
    logic [PSK_HALF-1:0] psk_window_second;
  } burst_t;

  typedef struct packed {
    logic       found;
    logic       access_burst;
    logic [1:0] tsc_set;
    logic [2:0] tsc;
  } detect_t;

  localparam logic [NRM_LEN-1:0] NRM_TAB [NRM_SETS][TSC_CODES] = '{
    '{
      26'b00100101110000100010010111,
      26'b00101101110111100010110111,
      26'b01000011101110100100001110,
      26'b01000111101101000100011110,
      26'b00011010111001000001101011,
      26'b01001110101100000100111010,
      26'b10100111110110001010011111,
      26'b11101111000100101110111100
    },
    '{
      26'b01100010001001001111010111,
      26'b01011110100110111011100001,
      26'b01000001011000111011101100,
      26'b00101101110111001111010000,
      26'b01110100111101001110111110,
      26'b01000001001101010011110011,
      26'b00010000110100001101110101,
      26'b01000101110011111100101001
    },
    '{
      26'b11000010010001111010100010,
      26'b00101111100010010100001000,
      26'b11001000111110111010110110,
      26'b00110000101001100000101100,
      26'b00011110101110100001000110,
      26'b11001111010101111001000000,
      26'b10111001101011111100010000,
      26'b11100101111011100000100100
    },
    '{
      26'b11001110100000100011010000,
      26'b01100010000101000101110000,
      26'b11100100000101010011100000,
      26'b01101100111110101000011000,
      26'b11011000010000100010110000,
      26'b11010011111110100011010110,
      26'b00100111111100101010110000,
      26'b01011100000010100110001110
    }
  };

  localparam logic [ACC_LEN-1:0] ACC_TAB [ACC_SEQS] = '{
    41'b0100101101_1111111001_1001101010_1000111100_0,
    41'b0101010011_1110001000_0110001011_1100100110_1,
    41'b1110111100_1001110101_0110000011_0110111011_1,
    41'b1100100111_0001001110_0000000011_0101011001_0
  };

  localparam logic [2:0] ACC_CODE [ACC_SEQS] = '{3'd0, 3'd1, 3'd2, 3'd4};

  localparam logic [SYN_LEN-1:0] SYN_TAB [SYN_SEQS] = '{
    64'b10111001_01100010_00000100_00001111_00101101_01000101_01110110_00011011,
    64'b11101110_01101011_00101000_00111110_11110100_01111110_11001011_00010101,
    64'b11101100_00110111_01010001_01011010_01111000_00010000_00100011_01001110,
    64'b10111010_00111101_11010110_11110100_10001011_01000000_10001110_10011000
  };

  localparam logic [PSK_LEN-1:0] PSK_TAB [PSK_SETS][TSC_CODES] = '{
    '{
  78'b11111100_11111110_01111001_00100111_11111111_11001111_11111100_11111110_01111001_001001,
  78'b11111100_11110010_01111001_00100111_10010010_01001111_11111100_11110010_01111001_001001,
  78'b11100111_11111111_11001001_00111100_10010011_11001111_11100111_11111111_11001001_001111,
  78'b11100111_11111110_01001001_00111100_10011110_01111111_11100111_11111110_01001001_001111,
  78'b11111111_10010011_11001111_00100100_11111110_01111111_11111111_10010011_11001111_001001,
  78'b11100111_11110010_01001111_00111100_10011111_11111111_11100111_11110010_01001111_001111,
  78'b00111100_11111110_01001001_00100111_10010011_11111111_00111100_11111110_01001001_001001,
  78'b00100100_11110010_01001001_11111111_10011111_11001111_00100100_11110010_01001001_111111
    },
    '{
  78'b11111111_11111110_01111001_00111111_11111110_01111001_11111100_10010011_11001001_001111,
  78'b11100100_10010011_11001001_11100111_10010010_01001001_11111100_10011110_01001111_111111,
  78'b00111100_11111110_01001001_11100111_10010010_01001001_11100111_10011111_11001001_111111,
  78'b11111100_11110010_01001111_00100100_10011110_01001001_00111111_10011110_01001001_111111,
  78'b11100100_10010011_11001111_11100100_11111111_11111111_00111100_10011111_11111001_111111,
  78'b11100111_10010010_01001111_00111100_10010011_11001001_11111111_11110011_11111001_111111,
  78'b00100100_10010011_11001111_00100111_10011111_11111001_00100111_10010010_01111001_111111,
  78'b00100100_10010010_01001111_11100111_10011110_01001111_11100111_11111111_11111001_001111
    }
  };

endpackage

// ===== hdl/gsm_burst_training_sequence_detect.sv =====
// ----------------------------------------------------------------------------
// gsm_burst_training_sequence_detect
// Exact-match detector for GSM normal, access, sync and 8-PSK training
// sequences in one hard-bit burst.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one burst word: the request
//   flags and the burst windows cut at the standard training positions, the
//   first burst bit in each window's MSB.
//   Output channel (out_valid/out_ready) carries one result word per burst:
//   found, access_burst, tsc_set and tsc; all zero when nothing matched.
//   From acceptance the burst is held in the input register while the
//   comparators and priority encoder feed the result register, which
//   drives out_valid.
//   Throughput is one burst per cycle while out_ready stays high; the rate is
//   set by the single comparator bank between the input and result registers.
//   When out_ready is low the result register holds its word and the input
//   register still accepts one more burst; in_ready drops only when both
//   registers are full.
//   Synchronous reset (rst) clears both valid flags; the data is not reset.
// ----------------------------------------------------------------------------
module gsm_burst_training_sequence_detect (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_nope,
  input  logic [1:0]  modulation,
  input  logic [2:0]  timeslot,
  input  logic [25:0] normal_window,
  input  logic [40:0] access_window,
  input  logic [63:0] sync_window,
  input  logic [38:0] psk_window_first,
  input  logic [38:0] psk_window_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic        access_burst,
  output logic [1:0]  tsc_set,
  output logic [2:0]  tsc
);

  gbtsd_pkg::burst_t  burst;
  logic               burst_valid;
  gbtsd_pkg::detect_t detect;
  gbtsd_pkg::detect_t result;
  logic               advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !burst_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
    end else if (in_ready) begin
      burst_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      burst <= '{is_nope:           is_nope,
                 modulation:        modulation,
                 timeslot:          timeslot,
                 normal_window:     normal_window,
                 access_window:     access_window,
                 sync_window:       sync_window,
                 psk_window_first:  psk_window_first,
                 psk_window_second: psk_window_second};
    end
  end

  gbtsd_match u_match (
    .burst  (burst),
    .detect (detect)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= burst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && burst_valid) begin
      result <= detect;
    end
  end

  assign found        = result.found;
  assign access_burst = result.access_burst;
  assign tsc_set      = result.tsc_set;
  assign tsc          = result.tsc;

endmodule

// ===== hdl/gbtsd_match.sv =====
// ----------------------------------------------------------------------------
// gbtsd_match
// Compares the windows of one registered burst against every sequence table
// in parallel and picks the first hit in priority order among the tables that the modulation selects.
// ----------------------------------------------------------------------------
module gbtsd_match (
  input  gbtsd_pkg::burst_t  burst,
  output gbtsd_pkg::detect_t detect
);

  logic [gbtsd_pkg::NRM_SETS-1:0][gbtsd_pkg::TSC_CODES-1:0] nrm_hit;
  logic [gbtsd_pkg::PSK_SETS-1:0][gbtsd_pkg::TSC_CODES-1:0] psk_hit;
  logic [gbtsd_pkg::ACC_SEQS-1:0]                           acc_hit;
  logic [gbtsd_pkg::SYN_SEQS-1:0]                           syn_hit;
  logic [gbtsd_pkg::PSK_LEN-1:0]                            psk_word;

  assign psk_word = {burst.psk_window_first, burst.psk_window_second};

  always_comb begin
    for (int j = 0; j < gbtsd_pkg::NRM_SETS; j++) begin
      for (int k = 0; k < gbtsd_pkg::TSC_CODES; k++) begin
        nrm_hit[j][k] = (burst.normal_window == gbtsd_pkg::NRM_TAB[j][k]);
      end
    end
    for (int j = 0; j < gbtsd_pkg::PSK_SETS; j++) begin
      for (int k = 0; k < gbtsd_pkg::TSC_CODES; k++) begin
        psk_hit[j][k] = (psk_word == gbtsd_pkg::PSK_TAB[j][k]);
      end
    end
    for (int k = 0; k < gbtsd_pkg::ACC_SEQS; k++) begin
      acc_hit[k] = (burst.access_window == gbtsd_pkg::ACC_TAB[k]);
    end
    for (int k = 0; k < gbtsd_pkg::SYN_SEQS; k++) begin
      syn_hit[k] = (burst.sync_window == gbtsd_pkg::SYN_TAB[k]);
    end
  end

  // Walk from lowest to highest priority so the first hit is written last.
  always_comb begin
    detect = '0;
    if (!burst.is_nope) begin
      case (gbtsd_pkg::modulation_t'(burst.modulation))
        gbtsd_pkg::MOD_GMSK: begin
          if (burst.timeslot == 3'd0) begin
            for (int k = gbtsd_pkg::SYN_SEQS - 1; k >= 0; k--) begin
              if (syn_hit[k]) begin
                detect.found        = 1'b1;
                detect.access_burst = 1'b0;
                detect.tsc_set      = 2'd0;
                detect.tsc          = 3'(k);
              end
            end
          end
          for (int k = gbtsd_pkg::ACC_SEQS - 1; k >= 0; k--) begin
            if (acc_hit[k]) begin
              detect.found        = 1'b1;
              detect.access_burst = 1'b1;
              detect.tsc_set      = 2'd0;
              detect.tsc          = gbtsd_pkg::ACC_CODE[k];
            end
          end
          for (int j = gbtsd_pkg::NRM_SETS - 1; j >= 0; j--) begin
            for (int k = gbtsd_pkg::TSC_CODES - 1; k >= 0; k--) begin
              if (nrm_hit[j][k]) begin
                detect.found        = 1'b1;
                detect.access_burst = 1'b0;
                detect.tsc_set      = 2'(j);
                detect.tsc          = 3'(k);
              end
            end
          end
        end
        gbtsd_pkg::MOD_8PSK: begin
          for (int j = gbtsd_pkg::PSK_SETS - 1; j >= 0; j--) begin
            for (int k = gbtsd_pkg::TSC_CODES - 1; k >= 0; k--) begin
              if (psk_hit[j][k]) begin
                detect.found        = 1'b1;
                detect.access_burst = 1'b0;
                detect.tsc_set      = 2'(j);
                detect.tsc          = 3'(k);
              end
            end
          end
        end
        default: begin
          detect = '0;
        end
      endcase
    end
  end

endmodule
